// ===== design/fpu_register_file_fr_remap_core_macros.svh =====
// Assertion macros shared by the register file remap block.
`ifndef FPU_REGISTER_FILE_FR_REMAP_CORE_MACROS_SVH
`define FPU_REGISTER_FILE_FR_REMAP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frr assertion failed");

`endif

// ===== design/frr_pkg.sv =====
// Package with types, codes and constants of the register file remap block.
`timescale 1ns / 1ps
`default_nettype none

package frr_pkg;

  localparam int unsigned WORDS      = 32;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned SW_CNT_W   = 6;
  localparam logic [SW_CNT_W-1:0] SW_LAST = 6'd32;

  // Operation codes of the func field.
  localparam logic [2:0] FUNC_RD_S = 3'd0;
  localparam logic [2:0] FUNC_WR_S = 3'd1;
  localparam logic [2:0] FUNC_RD_D = 3'd2;
  localparam logic [2:0] FUNC_WR_D = 3'd3;
  localparam logic [2:0] FUNC_SET  = 3'd4;

  typedef struct packed {
    logic [2:0]        func;
    logic [ADDR_W-1:0] reg_index;
    logic [WORD_W-1:0] write_value;
    logic              new_fr;
  } frr_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              fr_now;
  } frr_out_t;

  // Memory request from the controller to both banks.
  typedef struct packed {
    logic              we;
    logic              wbank;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } frr_mem_req_t;

  // Registered read data of both banks.
  typedef struct packed {
    logic [WORD_W-1:0] a0;
    logic [WORD_W-1:0] b0;
    logic [WORD_W-1:0] a1;
    logic [WORD_W-1:0] b1;
  } frr_mem_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWITCH
  } frr_state_t;

endpackage

`default_nettype wire

// ===== design/frr_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module frr_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== design/frr_ctrl.sv =====
// Controller: access sequencing, mode switch walk and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "fpu_register_file_fr_remap_core_macros.svh"

module frr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire frr_pkg::frr_in_t      in_item,
  output logic                       busy,
  output frr_pkg::frr_out_t          out_item,
  output logic                       out_valid,
  output frr_pkg::frr_mem_req_t      mem_req,
  input  wire frr_pkg::frr_mem_rsp_t mem_rsp
);

  frr_pkg::frr_state_t state_r, state_nxt;
  logic                          fr_r, fr_nxt;
  logic [frr_pkg::WORDS-1:0]     valid_r, valid_nxt;
  logic [frr_pkg::SW_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  frr_pkg::frr_out_t             out_r, out_nxt;
  frr_pkg::frr_in_t              op_r, op_nxt;
  logic [frr_pkg::ADDR_W-1:0]    word_r, word_nxt;
  logic                          half_r, half_nxt;
  logic                          va_r, va_nxt;
  logic                          vb_r, vb_nxt;

  logic [frr_pkg::ADDR_W-1:0]    word_map;
  logic                          half_map;
  logic                          is_switch;
  logic [frr_pkg::SW_CNT_W-1:0]  wr_full;
  logic [frr_pkg::ADDR_W-1:0]    sw_rd_idx;
  logic [frr_pkg::ADDR_W-1:0]    sw_wr_idx;
  logic                          sw_half;
  logic [frr_pkg::WORD_W-1:0]    old_a;
  logic [frr_pkg::WORD_W-1:0]    old_b;
  logic [frr_pkg::WORD_W-1:0]    rv;
  logic                          in_switch;
  logic                          sw_done;
  logic                          res_due;

  // Register number to word and half under the current mode.
  always_comb begin
    word_map  = fr_r ? in_item.reg_index : {1'b0, in_item.reg_index[frr_pkg::ADDR_W-1:1]};
    half_map  = fr_r ? 1'b0 : in_item.reg_index[0];
    is_switch = (in_item.func == frr_pkg::FUNC_SET) && (in_item.new_fr != fr_r);
    sw_rd_idx = cnt_r[frr_pkg::ADDR_W-1:0];
    wr_full   = cnt_r - frr_pkg::SW_CNT_W'(1);
    sw_wr_idx = wr_full[frr_pkg::ADDR_W-1:0];
    sw_half   = op_r.new_fr ? sw_wr_idx[0] : sw_wr_idx[frr_pkg::ADDR_W-1];
    in_switch = (state_r == frr_pkg::ST_SWITCH);
    sw_done   = in_switch && (cnt_r == frr_pkg::SW_LAST);
    res_due   = (state_r == frr_pkg::ST_EXEC) || sw_done;
  end

  // Active bank data; never-written entries of bank 0 read as zero.
  always_comb begin
    old_a = va_r ? (fr_r ? mem_rsp.a1 : mem_rsp.a0) : '0;
    old_b = vb_r ? (fr_r ? mem_rsp.b1 : mem_rsp.b0) : '0;
  end

  // Next state, memory request and result.
  always_comb begin
    state_nxt     = state_r;
    fr_nxt        = fr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    op_nxt        = op_r;
    word_nxt      = word_r;
    half_nxt      = half_r;
    rv            = '0;

    mem_req.we      = 1'b0;
    mem_req.wbank   = fr_r;
    mem_req.waddr   = word_r;
    mem_req.wdata   = op_r.write_value;
    mem_req.raddr_a = word_map;
    mem_req.raddr_b = word_map;

    unique case (state_r)
      frr_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt   = in_item;
          word_nxt = word_map;
          half_nxt = half_map;
          cnt_nxt  = '0;
          state_nxt = is_switch ? frr_pkg::ST_SWITCH : frr_pkg::ST_EXEC;
        end
      end
      frr_pkg::ST_EXEC: begin
        unique case (op_r.func)
          frr_pkg::FUNC_RD_S: begin
            rv = half_r ? {{frr_pkg::HALF_W{1'b0}}, old_a[frr_pkg::WORD_W-1:frr_pkg::HALF_W]}
                        : {{frr_pkg::HALF_W{1'b0}}, old_a[frr_pkg::HALF_W-1:0]};
          end
          frr_pkg::FUNC_WR_S: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = half_r
              ? {op_r.write_value[frr_pkg::HALF_W-1:0], old_a[frr_pkg::HALF_W-1:0]}
              : {old_a[frr_pkg::WORD_W-1:frr_pkg::HALF_W],
                 op_r.write_value[frr_pkg::HALF_W-1:0]};
          end
          frr_pkg::FUNC_RD_D: begin
            rv = old_a;
          end
          frr_pkg::FUNC_WR_D: begin
            mem_req.we = 1'b1;
          end
          default: begin
          end
        endcase
        out_nxt.read_value = rv;
        out_nxt.fr_now     = fr_r;
        out_valid_nxt      = 1'b1;
        state_nxt          = frr_pkg::ST_IDLE;
      end
      frr_pkg::ST_SWITCH: begin
        // Read two old words of the active bank, write the permuted word to the other.
        if (op_r.new_fr) begin
          mem_req.raddr_a = {1'b0, sw_rd_idx[frr_pkg::ADDR_W-1:1]};
          mem_req.raddr_b = {1'b1, sw_rd_idx[frr_pkg::ADDR_W-1:1]};
        end else begin
          mem_req.raddr_a = {sw_rd_idx[frr_pkg::ADDR_W-2:0], 1'b0};
          mem_req.raddr_b = {sw_rd_idx[frr_pkg::ADDR_W-2:0], 1'b1};
        end
        mem_req.we    = (cnt_r != '0);
        mem_req.wbank = ~fr_r;
        mem_req.waddr = sw_wr_idx;
        mem_req.wdata = sw_half
          ? {old_b[frr_pkg::WORD_W-1:frr_pkg::HALF_W], old_a[frr_pkg::WORD_W-1:frr_pkg::HALF_W]}
          : {old_b[frr_pkg::HALF_W-1:0], old_a[frr_pkg::HALF_W-1:0]};
        cnt_nxt = cnt_r + frr_pkg::SW_CNT_W'(1);
        if (cnt_r == frr_pkg::SW_LAST) begin
          fr_nxt             = op_r.new_fr;
          out_nxt.read_value = '0;
          out_nxt.fr_now     = op_r.new_fr;
          out_valid_nxt      = 1'b1;
          state_nxt          = frr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frr_pkg::ST_IDLE;
      end
    endcase
  end

  // Validity of the addresses being read, and written entries of bank 0.
  always_comb begin
    va_nxt    = fr_r | valid_r[mem_req.raddr_a];
    vb_nxt    = fr_r | valid_r[mem_req.raddr_b];
    valid_nxt = valid_r;
    if (mem_req.we && !mem_req.wbank) begin
      valid_nxt[mem_req.waddr] = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frr_pkg::ST_IDLE;
      fr_r        <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fr_r        <= fr_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    op_r   <= op_nxt;
    word_r <= word_nxt;
    half_r <= half_nxt;
    va_r   <= va_nxt;
    vb_r   <= vb_nxt;
  end

  assign busy      = (state_r != frr_pkg::ST_IDLE);
  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  // A result only follows an access or the end of a mode switch.
  `FRR_ASSERT_IMP(a_out_source, clk, rst_n, out_valid_r, $past(res_due))
  // The switch walk never writes the bank it is reading.
  `FRR_ASSERT_IMP(a_switch_bank, clk, rst_n, in_switch && mem_req.we, mem_req.wbank != fr_r)
  // An accepted transaction always makes the block busy.
  `FRR_ASSERT_NXT(a_accept_busy, clk, rst_n, !busy && start, busy)
  // The mode only changes at the end of a switch walk.
  `FRR_ASSERT_NXT(a_mode_stable, clk, rst_n, !sw_done, $stable(fr_r))

endmodule

`default_nettype wire

// ===== design/fpu_register_file_fr_remap_core.sv =====
// Top level of the floating-point register file with FR mode remapping.
`timescale 1ns / 1ps
`default_nettype none

// Usage notes.
// A transaction is offered on in_item with start and is taken at the rising
// edge where start is high and busy is low. Every transaction gives exactly one
// result on out_item, shown for a single cycle with out_valid high; the receiver
// cannot hold it off and must take it in that cycle.
// Reads, writes and set-mode transactions that keep the mode pass through EXEC:
// the word is read from the active bank, a write puts the new word back, and
// the result strobe follows in the cycle after. busy is low again while that
// strobe is shown, so the next transaction can be taken in that cycle.
// A set-mode transaction that changes FR walks all 32 words, reading two old
// words of the active bank per cycle and writing the permuted word to the other
// bank; busy stays high for the whole walk, the banks then swap roles and the
// result strobe is shown in the next cycle.
// Reset (rst_n low, synchronous) clears FR to 0 and marks every word as zero
// at once through per-word valid bits, so no clearing pass is needed and
// transactions are taken in the first cycle after reset.

module fpu_register_file_fr_remap_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire frr_pkg::frr_in_t in_item,
  output logic                  busy,
  output frr_pkg::frr_out_t     out_item,
  output logic                  out_valid
);

  frr_pkg::frr_mem_req_t mem_req;
  frr_pkg::frr_mem_rsp_t mem_rsp;
  logic                  we0;
  logic                  we1;

  // Bank write enables.
  assign we0 = mem_req.we & ~mem_req.wbank;
  assign we1 = mem_req.we &  mem_req.wbank;

  frr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_item  (out_item),
    .out_valid (out_valid),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  // Bank 0: active while FR is 0.
  frr_ram #(
    .DEPTH (frr_pkg::WORDS),
    .WIDTH (frr_pkg::WORD_W)
  ) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.raddr_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_a (mem_rsp.a0),
    .rdata_b (mem_rsp.b0)
  );

  // Bank 1: active while FR is 1.
  frr_ram #(
    .DEPTH (frr_pkg::WORDS),
    .WIDTH (frr_pkg::WORD_W)
  ) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.raddr_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_a (mem_rsp.a1),
    .rdata_b (mem_rsp.b1)
  );

endmodule

`default_nettype wire
